// ----- src/pwfp_pkg.sv -----
// Shared constants, types and codes for the protobuf wire field parser.
`timescale 1ns / 1ps

package pwfp_pkg;

   // Width of the payload byte counter; lengths that do not fit are rejected.
   localparam int LEN_WIDTH = 32;

   localparam int VARINT_MAX_BYTES = 10;
   localparam int VARINT_DIGIT_BITS = 7;

   localparam logic [63:0] LEN_MAX = (LEN_WIDTH >= 64) ? {64{1'b1}} :
                                     ((64'd1 << LEN_WIDTH) - 64'd1);

   // Parser phases
   localparam logic [2:0] PH_TAG     = 3'd0;
   localparam logic [2:0] PH_VALUE   = 3'd1;
   localparam logic [2:0] PH_LENGTH  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_DISCARD = 3'd4;

   // Result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG = 2'd1;
   localparam logic [1:0] ERR_BAD_WIRE = 2'd2;
   localparam logic [1:0] ERR_TRUNC    = 2'd3;

   // Wire types
   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_I64    = 3'd1;
   localparam logic [2:0] WIRE_LEN    = 3'd2;
   localparam logic [2:0] WIRE_I32    = 3'd5;

   localparam logic [63:0] I64_BYTES = 64'd8;
   localparam logic [63:0] I32_BYTES = 64'd4;

   typedef logic [2:0] phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [63:0]            accumulator;
      logic [3:0]             varint_byte_count;
      logic [31:0]            held_field;
      logic [2:0]             held_wire;
      logic [LEN_WIDTH-1:0]   bytes_left;
   } state_type;

   localparam state_type STATE_START = '{phase: PH_TAG, default: '0};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } in_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] field_number;
      logic [2:0]  wire_type;
      logic [63:0] value;
      logic [7:0]  payload_byte;
      logic [1:0]  error_code;
      logic        msg_end;
   } result_type;

endpackage

// ----- src/pwfp_if.sv -----
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface pwfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pwfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] field_number;
   logic [2:0]  wire_type;
   logic [63:0] value;
   logic [7:0]  payload_byte;
   logic [1:0]  error_code;
   logic        msg_end;

   modport source (output valid, output kind, output field_number, output wire_type,
                   output value, output payload_byte, output error_code,
                   output msg_end, input ready);
   modport sink   (input valid, input kind, input field_number, input wire_type,
                   input value, input payload_byte, input error_code,
                   input msg_end, output ready);
endinterface

// ----- src/pwfp_in_stage.sv -----
// Input register stage that captures one byte transfer at a time.
`timescale 1ns / 1ps

module pwfp_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   pwfp_req_if.sink             req_chan,
   input  logic                 advance,
   output logic                 item_valid,
   output pwfp_pkg::in_item_type item
);
   import pwfp_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   in_item_type item_ff;

   // The register may refill in the same cycle as its contents move on.
   assign req_chan.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_chan.ready) begin
         valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_chan.valid && req_chan.ready) begin
         item_ff.data_byte <= req_chan.data_byte;
         item_ff.last_byte <= req_chan.last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// ----- src/pwfp_step.sv -----
// Next-state and result logic for one message byte.
`timescale 1ns / 1ps

module pwfp_step (
   input  pwfp_pkg::state_type   state_cur,
   input  pwfp_pkg::in_item_type item,
   output pwfp_pkg::state_type   state_nxt,
   output logic                  res_valid,
   output pwfp_pkg::result_type  res
);
   import pwfp_pkg::*;

   logic [5:0]  shift;
   logic [63:0] acc_new;
   logic [3:0]  cnt_new;
   logic        more;
   logic        too_long;
   logic        fail;
   logic [1:0]  fail_code;
   logic        restart;
   logic        emit;
   logic [1:0]  kind;
   logic [63:0] value;
   logic [7:0]  pay;
   state_type   body;

   assign shift    = 6'(state_cur.varint_byte_count * VARINT_DIGIT_BITS);
   assign acc_new  = state_cur.accumulator | ({57'd0, item.data_byte[6:0]} << shift);
   assign cnt_new  = state_cur.varint_byte_count + 4'd1;
   assign more     = item.data_byte[7];
   assign too_long = more && (cnt_new >= 4'(VARINT_MAX_BYTES));

   always_comb begin
      body      = state_cur;
      fail      = 1'b0;
      fail_code = ERR_NONE;
      restart   = 1'b0;
      emit      = 1'b0;
      kind      = KIND_HEADER;
      value     = '0;
      pay       = '0;

      case (state_cur.phase)
         PH_TAG: begin
            body.accumulator       = acc_new;
            body.varint_byte_count = cnt_new;
            if (too_long) begin
               fail      = 1'b1;
               fail_code = ERR_TOO_LONG;
            end else if (more) begin
               if (item.last_byte) begin
                  fail      = 1'b1;
                  fail_code = ERR_TRUNC;
               end
            end else begin
               body.held_field        = acc_new[34:3];
               body.held_wire         = acc_new[2:0];
               body.accumulator       = '0;
               body.varint_byte_count = '0;
               case (acc_new[2:0])
                  WIRE_VARINT, WIRE_LEN: begin
                     if (item.last_byte) begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNC;
                     end else begin
                        body.phase = (acc_new[2:0] == WIRE_VARINT) ? PH_VALUE : PH_LENGTH;
                     end
                  end
                  WIRE_I64, WIRE_I32: begin
                     if (item.last_byte) begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNC;
                     end else begin
                        value = (acc_new[2:0] == WIRE_I64) ? I64_BYTES : I32_BYTES;
                        emit  = 1'b1;
                        body.bytes_left = LEN_WIDTH'(value);
                        body.phase      = PH_PAYLOAD;
                     end
                  end
                  default: begin
                     fail      = 1'b1;
                     fail_code = ERR_BAD_WIRE;
                  end
               endcase
            end
         end

         PH_VALUE, PH_LENGTH: begin
            body.accumulator       = acc_new;
            body.varint_byte_count = cnt_new;
            if (too_long) begin
               fail      = 1'b1;
               fail_code = ERR_TOO_LONG;
            end else if (more) begin
               if (item.last_byte) begin
                  fail      = 1'b1;
                  fail_code = ERR_TRUNC;
               end
            end else if (state_cur.phase == PH_VALUE) begin
               emit    = 1'b1;
               value   = acc_new;
               restart = 1'b1;
            end else if (acc_new > LEN_MAX) begin
               fail      = 1'b1;
               fail_code = ERR_TRUNC;
            end else if ((acc_new != '0) && item.last_byte) begin
               fail      = 1'b1;
               fail_code = ERR_TRUNC;
            end else begin
               emit  = 1'b1;
               value = acc_new;
               if (acc_new == '0) begin
                  restart = 1'b1;
               end else begin
                  body.bytes_left        = acc_new[LEN_WIDTH-1:0];
                  body.accumulator       = '0;
                  body.varint_byte_count = '0;
                  body.phase             = PH_PAYLOAD;
               end
            end
         end

         PH_PAYLOAD: begin
            if ((state_cur.bytes_left > LEN_WIDTH'(1)) && item.last_byte) begin
               fail      = 1'b1;
               fail_code = ERR_TRUNC;
            end else begin
               emit = 1'b1;
               kind = KIND_PAYLOAD;
               pay  = item.data_byte;
               if ((state_cur.bytes_left <= LEN_WIDTH'(1)) || item.last_byte) begin
                  restart = 1'b1;
               end else begin
                  body.bytes_left = state_cur.bytes_left - LEN_WIDTH'(1);
               end
            end
         end

         default: begin
            // Discarding the rest of a failed message.
            restart = item.last_byte;
         end
      endcase

      // Results carry the field held at the moment they are raised.
      res.field_number = body.held_field;
      res.wire_type    = body.held_wire;
      res.kind         = fail ? KIND_ERROR : kind;
      res.value        = fail ? 64'd0 : value;
      res.payload_byte = fail ? 8'd0 : pay;
      res.error_code   = fail_code;
      res.msg_end      = item.last_byte;
      res_valid        = emit || fail;

      state_nxt = body;
      if (fail) begin
         if (item.last_byte) begin
            state_nxt = STATE_START;
         end else begin
            state_nxt.phase = PH_DISCARD;
         end
      end else if (restart) begin
         state_nxt = STATE_START;
      end
   end

endmodule

// ----- src/protobuf_wire_field_parser.sv -----
// Top level of the protobuf wire-format field parser.
`timescale 1ns / 1ps

// Parses an encoded protobuf message at one byte per clock cycle while the output
// takes results: a byte transfer may be offered in every cycle and gives at most
// one result (field header, payload byte or error). Each byte passes an input
// register, the decode logic and the result register, where its result is
// offered on the output until it is taken. The parser state loop closes
// through the decode step, which sets the rate. Input ready follows output
// ready combinationally when both registers are full. No clearing pass is
// needed after reset.
module protobuf_wire_field_parser (
   input  logic        clock,
   input  logic        reset,
   pwfp_req_if.sink    req_chan,
   pwfp_rsp_if.source  rsp_chan
);
   import pwfp_pkg::*;

   logic        item_valid;
   in_item_type item;
   logic        out_free;
   logic        fire;
   logic        res_valid;
   result_type  res;
   state_type   state_ff;
   state_type   state_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign fire     = item_valid && out_free;

   pwfp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   pwfp_step u_step (
      .state_cur (state_ff),
      .item      (item),
      .state_nxt (state_in),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_data_ff.kind;
   assign rsp_chan.field_number = rsp_data_ff.field_number;
   assign rsp_chan.wire_type    = rsp_data_ff.wire_type;
   assign rsp_chan.value        = rsp_data_ff.value;
   assign rsp_chan.payload_byte = rsp_data_ff.payload_byte;
   assign rsp_chan.error_code   = rsp_data_ff.error_code;
   assign rsp_chan.msg_end      = rsp_data_ff.msg_end;

   // A field in its payload always has bytes still due.
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_PAYLOAD |-> state_ff.bytes_left != '0)
      else $error("payload phase with no bytes left");

   // The last byte of a message always leaves the parser expecting a tag.
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_byte |=> state_ff.phase == PH_TAG)
      else $error("parser not back at tag after last byte");

   // Error results carry a code, other results none.
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.kind == KIND_ERROR) == (rsp_data_ff.error_code != ERR_NONE)))
      else $error("result kind and error code disagree");

   // A varint never holds ten or more bytes between transfers.
   a_varint_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase != PH_DISCARD |-> state_ff.varint_byte_count < 4'(VARINT_MAX_BYTES))
      else $error("varint byte count out of range");

   // A stalled result register never loses its transfer.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result overwritten");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the protobuf wire field parser.
`timescale 1ns / 1ps

module tb;
   import pwfp_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int RANDOM_BYTES = 1050;

   // Wire types that the parser rejects.
   localparam logic [2:0] WIRE_SGROUP = 3'd3;
   localparam logic [2:0] WIRE_EGROUP = 3'd4;
   localparam logic [2:0] WIRE_RSVD6  = 3'd6;
   localparam logic [2:0] WIRE_RSVD7  = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pwfp_req_if req_link ();
   pwfp_rsp_if rsp_link ();

   protobuf_wire_field_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_link),
      .rsp_chan (rsp_link)
   );

   always #6 clock = ~clock;

   in_item_type message_bytes[$];
   logic [7:0]  msg_buf[$];
   result_type  parsed_results[$];
   int          total_bytes;
   int          accepted_count = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          dropped_bytes = 0;
   logic        calm;

   // Shadow copy of the parser state.
   logic [2:0]  ps_phase;
   logic [63:0] ps_acc;
   logic [3:0]  ps_count;
   logic [31:0] ps_field;
   logic [2:0]  ps_wire;
   logic [63:0] ps_left;

   // A window in which neither side idles.
   assign calm = (cycle_count >= 300) && (cycle_count < 700);

   function automatic void restart_field();
      ps_phase = PH_TAG;
      ps_acc   = '0;
      ps_count = '0;
      ps_field = '0;
      ps_wire  = '0;
      ps_left  = '0;
   endfunction

   function automatic int varint_take(input logic [7:0] b);
      logic [63:0] digit;
      digit = {57'd0, b[6:0]} << ((ps_count % VARINT_MAX_BYTES) * VARINT_DIGIT_BITS);
      ps_acc = ps_acc | digit;
      ps_count = ps_count + 4'd1;
      if (!b[7])
         return 1;
      if (ps_count >= VARINT_MAX_BYTES)
         return -1;
      return 0;
   endfunction

   function automatic result_type make_result(input logic [1:0] kind, input logic [63:0] value,
                                              input logic [7:0] pay, input logic [1:0] code,
                                              input logic last);
      result_type r;
      r.kind = kind;
      r.field_number = ps_field;
      r.wire_type = ps_wire;
      r.value = value;
      r.payload_byte = pay;
      r.error_code = code;
      r.msg_end = last;
      return r;
   endfunction

   function automatic result_type raise_error(input logic [1:0] code, input logic last);
      result_type r;
      r = make_result(KIND_ERROR, 64'd0, 8'd0, code, last);
      if (last)
         restart_field();
      else
         ps_phase = PH_DISCARD;
      return r;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic last,
                              output bit got, output result_type res);
      int step;
      got = 1'b1;
      res = '0;
      case (ps_phase)
         PH_TAG: begin
            step = varint_take(b);
            if (step < 0) begin
               res = raise_error(ERR_TOO_LONG, last);
            end else if (step == 0) begin
               if (last)
                  res = raise_error(ERR_TRUNC, last);
               else
                  got = 1'b0;
            end else begin
               ps_field = ps_acc[34:3];
               ps_wire  = ps_acc[2:0];
               ps_acc   = '0;
               ps_count = '0;
               if (ps_wire == WIRE_VARINT || ps_wire == WIRE_LEN) begin
                  if (last) begin
                     res = raise_error(ERR_TRUNC, last);
                  end else begin
                     ps_phase = (ps_wire == WIRE_VARINT) ? PH_VALUE : PH_LENGTH;
                     got = 1'b0;
                  end
               end else if (ps_wire == WIRE_I64 || ps_wire == WIRE_I32) begin
                  if (last) begin
                     res = raise_error(ERR_TRUNC, last);
                  end else begin
                     ps_left = (ps_wire == WIRE_I64) ? I64_BYTES : I32_BYTES;
                     res = make_result(KIND_HEADER, ps_left, 8'd0, ERR_NONE, 1'b0);
                     ps_phase = PH_PAYLOAD;
                  end
               end else begin
                  res = raise_error(ERR_BAD_WIRE, last);
               end
            end
         end
         PH_VALUE, PH_LENGTH: begin
            step = varint_take(b);
            if (step < 0) begin
               res = raise_error(ERR_TOO_LONG, last);
            end else if (step == 0) begin
               if (last)
                  res = raise_error(ERR_TRUNC, last);
               else
                  got = 1'b0;
            end else if (ps_phase == PH_VALUE) begin
               res = make_result(KIND_HEADER, ps_acc, 8'd0, ERR_NONE, last);
               restart_field();
            end else if (ps_acc > LEN_MAX || (ps_acc != 0 && last)) begin
               res = raise_error(ERR_TRUNC, last);
            end else begin
               res = make_result(KIND_HEADER, ps_acc, 8'd0, ERR_NONE, last);
               if (ps_acc == 0) begin
                  restart_field();
               end else begin
                  ps_left  = ps_acc;
                  ps_acc   = '0;
                  ps_count = '0;
                  ps_phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (ps_left > 1 && last) begin
               res = raise_error(ERR_TRUNC, last);
            end else begin
               res = make_result(KIND_PAYLOAD, 64'd0, b, ERR_NONE, last);
               if (ps_left <= 1 || last)
                  restart_field();
               else
                  ps_left = ps_left - 64'd1;
            end
         end
         default: begin
            got = 1'b0;
            if (last)
               restart_field();
         end
      endcase
   endtask

   // Stimulus building ------------------------------------------------------

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [60:0] rand_field();
      case ($urandom_range(0, 2))
         0: return 61'($urandom_range(0, 15));
         1: return 61'($urandom_range(16, 1 << 24));
         default: return 61'(rand64() >> 3);
      endcase
   endfunction

   function automatic logic [63:0] rand_value();
      case ($urandom_range(0, 4))
         0: return 64'($urandom_range(0, 127));
         1: return rand64() >> $urandom_range(0, 63);
         2: return rand64();
         3: return {64{1'b1}};
         default: return 64'd0;
      endcase
   endfunction

   function automatic int rand_pad();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
   endfunction

   task automatic put_byte(input logic [7:0] b);
      msg_buf.push_back(b);
   endtask

   // Little-endian base-128, optionally padded with redundant groups.
   task automatic put_varint(input logic [63:0] v, input int pad);
      int n;
      int total;
      logic [63:0] rest;
      n = 1;
      rest = v >> 7;
      while (rest != 0) begin
         n++;
         rest = rest >> 7;
      end
      total = (n + pad > VARINT_MAX_BYTES) ? VARINT_MAX_BYTES : n + pad;
      for (int i = 0; i < total; i++) begin
         rest = v >> (7 * i);
         put_byte({(i < total - 1) ? 1'b1 : 1'b0, rest[6:0]});
      end
   endtask

   task automatic put_good_field();
      logic [2:0] wire_sel;
      int len;
      case ($urandom_range(0, 3))
         0: wire_sel = WIRE_VARINT;
         1: wire_sel = WIRE_I64;
         2: wire_sel = WIRE_LEN;
         default: wire_sel = WIRE_I32;
      endcase
      put_varint({rand_field(), wire_sel}, rand_pad());
      if (wire_sel == WIRE_VARINT) begin
         put_varint(rand_value(), rand_pad());
      end else if (wire_sel == WIRE_LEN) begin
         len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
         put_varint(64'(len), rand_pad());
         repeat (len) put_byte(8'($urandom_range(0, 255)));
      end else begin
         repeat ((wire_sel == WIRE_I64) ? 8 : 4) put_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic put_garbage();
      int n;
      n = $urandom_range(1, 4);
      dropped_bytes += n;
      repeat (n) put_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic close_message();
      in_item_type item;
      while (msg_buf.size() > 0) begin
         item.data_byte = msg_buf.pop_front();
         item.last_byte = (msg_buf.size() == 0);
         message_bytes.push_back(item);
      end
   endtask

   task automatic add_message();
      int mode;
      int cut;
      int sel;
      logic [2:0] bad_wire;
      logic [63:0] len;
      repeat ($urandom_range(1, 4)) put_good_field();
      mode = $urandom_range(0, 99);
      if (mode < 72) begin
         close_message();
      end else if (mode < 84) begin
         // Message cut short at a random byte.
         cut = $urandom_range(1, msg_buf.size());
         while (msg_buf.size() > cut) void'(msg_buf.pop_back());
         close_message();
      end else if (mode < 89) begin
         case ($urandom_range(0, 3))
            0: bad_wire = WIRE_SGROUP;
            1: bad_wire = WIRE_EGROUP;
            2: bad_wire = WIRE_RSVD6;
            default: bad_wire = WIRE_RSVD7;
         endcase
         put_varint({rand_field(), bad_wire}, rand_pad());
         put_garbage();
         close_message();
      end else if (mode < 93) begin
         // Over-long varint in the tag, the value or the length.
         sel = $urandom_range(0, 2);
         if (sel != 0)
            put_varint({rand_field(), (sel == 1) ? WIRE_VARINT : WIRE_LEN}, 0);
         repeat (VARINT_MAX_BYTES) put_byte(8'h80 | 8'($urandom_range(0, 127)));
         if ($urandom_range(0, 1) == 0)
            put_garbage();
         close_message();
      end else if (mode < 96) begin
         // Length that does not fit the byte counter.
         len = rand64();
         if (LEN_WIDTH < 64)
            len[$urandom_range(LEN_WIDTH, 63)] = 1'b1;
         put_varint({rand_field(), WIRE_LEN}, 0);
         put_varint(len, 0);
         put_garbage();
         close_message();
      end else begin
         // Large legal length, ended after at most three payload bytes.
         len = LEN_MAX - 64'($urandom_range(0, 3));
         put_varint({rand_field(), WIRE_LEN}, 0);
         put_varint(len, 0);
         repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
         close_message();
      end
   endtask

   // Byte driver ------------------------------------------------------------

   always @(posedge clock) begin : drive_bytes
      bit got;
      result_type want;
      in_item_type item;
      bit busy;
      if (reset) begin
         req_link.valid <= 1'b0;
      end else begin
         busy = req_link.valid;
         if (req_link.valid && req_link.ready) begin
            decode_byte(req_link.data_byte, req_link.last_byte, got, want);
            if (got)
               parsed_results.push_back(want);
            accepted_count++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (message_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
               item = message_bytes.pop_front();
               req_link.valid     <= 1'b1;
               req_link.data_byte <= item.data_byte;
               req_link.last_byte <= item.last_byte;
            end else begin
               req_link.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor ---------------------------------------------------------

   always @(posedge clock) begin : watch_results
      result_type seen;
      result_type want;
      if (reset) begin
         rsp_link.ready <= 1'b0;
      end else begin
         if (rsp_link.valid && rsp_link.ready) begin
            seen.kind         = rsp_link.kind;
            seen.field_number = rsp_link.field_number;
            seen.wire_type    = rsp_link.wire_type;
            seen.value        = rsp_link.value;
            seen.payload_byte = rsp_link.payload_byte;
            seen.error_code   = rsp_link.error_code;
            seen.msg_end      = rsp_link.msg_end;
            if (parsed_results.size() == 0) begin
               $display("%0t: unexpected result kind %0d field %0d wire %0d value %h",
                        $time, seen.kind, seen.field_number, seen.wire_type, seen.value);
               fail_count++;
            end else begin
               want = parsed_results.pop_front();
               if (seen !== want) begin
                  $display({"%0t: mismatch: expected kind %0d field %0d wire %0d value %h ",
                            "byte %h err %0d end %0d"}, $time, want.kind, want.field_number,
                           want.wire_type, want.value, want.payload_byte, want.error_code,
                           want.msg_end);
                  $display({"%0t:           actual kind %0d field %0d wire %0d value %h ",
                            "byte %h err %0d end %0d"}, $time, seen.kind, seen.field_number,
                           seen.wire_type, seen.value, seen.payload_byte, seen.error_code,
                           seen.msg_end);
                  fail_count++;
               end
            end
         end
         rsp_link.ready <= calm || ($urandom_range(0, 99) >= 24);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      restart_field();

      // Varint, fixed32, empty and short length-delimited fields in one message.
      put_byte(8'h08); put_byte(8'h96); put_byte(8'h01);
      put_byte(8'h15); put_byte(8'haa); put_byte(8'hbb); put_byte(8'hcc); put_byte(8'hdd);
      put_byte(8'h1a); put_byte(8'h00);
      put_byte(8'h22); put_byte(8'h02); put_byte(8'hff); put_byte(8'h00);
      close_message();
      // Group-start wire type, then a dropped byte ending the message.
      put_byte({5'd1, WIRE_SGROUP});
      put_byte(8'h80);
      close_message();
      // Tag varint too long on the last byte: the too-long error wins over truncation.
      repeat (VARINT_MAX_BYTES) put_byte(8'h80);
      close_message();

      total_bytes = message_bytes.size();
      while (message_bytes.size() < total_bytes + RANDOM_BYTES + dropped_bytes)
         add_message();
      total_bytes = message_bytes.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_bytes || parsed_results.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
